// ===== hw/rtl/segorb_pkg.sv =====
// Package for the segment orbit step pipeline: widths, rotation constants,
// register indexes and the structs passed between stages. No dependencies.
`timescale 1ns / 1ps

package segorb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CRD_W    = 32;
    localparam int RADIUS_W = 31;
    localparam int DIF_W    = CRD_W + 1;
    localparam int PRD_W    = 2 * DIF_W;
    localparam int DOT_W    = PRD_W + 2;
    localparam int H_W      = FRAC_BITS + 1;
    localparam int HB_W     = H_W + 1 + DIF_W;
    localparam int Q_W      = DIF_W + 2;
    localparam int MAG_W    = Q_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int RR_W     = 2 * RADIUS_W;
    localparam int RAD_W    = SQ_W + 2;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int NUM_W    = MAG_W + FRAC_BITS + 1;

    // normalising shift: larger magnitude brought up to this bit
    localparam int NORM_BIT = 33;
    localparam int SH_W     = 6;
    localparam int GRP      = 7;
    localparam int NGRP     = MAG_W / GRP;
    localparam int LEAD_W   = 3;

    localparam int U_W   = H_W + 1;
    localparam int K_W   = FRAC_BITS + 1;
    localparam int P_W   = U_W + K_W;
    localparam int ACC_W = P_W + 1;
    localparam int RX_W  = H_W + 2;

    localparam longint ROT_C_L = ((longint'(2588) << FRAC_BITS) + 5000) / 10000;
    localparam longint ROT_S_L = ((longint'(9659) << FRAC_BITS) + 5000) / 10000;
    localparam logic signed [K_W-1:0] ROT_C = K_W'(ROT_C_L);
    localparam logic signed [K_W-1:0] ROT_S = K_W'(ROT_S_L);

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEG_END_X   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEG_END_Y   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORBIT_RAD   = 3'd4;

    typedef struct packed {
        logic signed [CRD_W-1:0] sx;
        logic signed [CRD_W-1:0] sy;
        logic signed [CRD_W-1:0] ex;
        logic signed [CRD_W-1:0] ey;
        logic [RADIUS_W-1:0]     radius;
    } cfg_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic                    last;
    } item_t;

    typedef struct packed {
        item_t                   item;
        logic signed [DIF_W-1:0] pax;
        logic signed [DIF_W-1:0] pay;
        logic [H_W-1:0]          h;
    } proj_t;

    typedef struct packed {
        item_t item;
        logic  zero;
        logic  far;
        logic  neg_x;
        logic  neg_y;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } norm_t;

    typedef struct packed {
        tag_t              tag;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic [ROOT_W-1:0] root;
    } root_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] new_x;
        logic signed [CRD_W-1:0] new_y;
        logic                    last;
    } result_t;

endpackage

// ===== hw/rtl/segorb_proj.sv =====
// Projection stages: offsets from segment start, dot product and length
// squared, then a one-bit-per-stage divider for h. Uses segorb_pkg.
`timescale 1ns / 1ps

module segorb_proj (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  segorb_pkg::item_t   in_item,
    input  segorb_pkg::cfg_t    cfg,
    output logic                out_valid,
    output segorb_pkg::proj_t   out_data
);
    import segorb_pkg::*;

    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic [FRAC_BITS:0] dv_reg;

    item_t it1_reg, it2_reg, it3_reg;
    logic signed [DIF_W-1:0] pax1_reg, pay1_reg, bax1_reg, bay1_reg;
    logic signed [DIF_W-1:0] pax2_reg, pay2_reg, pax3_reg, pay3_reg;
    logic signed [DIF_W-1:0] pax1_next, pay1_next, bax1_next, bay1_next;
    logic signed [PRD_W-1:0] pbx2_reg, pby2_reg, bbx2_reg, bby2_reg;
    logic signed [DOT_W-1:0] dot3_reg, dot3_next;
    logic [DOT_W-1:0]        len3_reg, len3_next;

    item_t                   dit_reg  [FRAC_BITS+1];
    logic signed [DIF_W-1:0] dpax_reg [FRAC_BITS+1];
    logic signed [DIF_W-1:0] dpay_reg [FRAC_BITS+1];
    logic [DOT_W-1:0]        dlen_reg [FRAC_BITS+1];
    logic [DOT_W-1:0]        drem_reg [FRAC_BITS+1];
    logic [DOT_W-1:0]        drem_next[FRAC_BITS+1];
    logic [FRAC_BITS-1:0]    dq_reg   [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]    dq_next  [FRAC_BITS+1];
    logic                    dzero_reg[FRAC_BITS+1];
    logic                    dfull_reg[FRAC_BITS+1];
    logic                    zero0, full0;

    proj_t out_reg, out_next;

    always_comb
    begin
        pax1_next = $signed({in_item.px[CRD_W-1], in_item.px}) - $signed({cfg.sx[CRD_W-1], cfg.sx});
        pay1_next = $signed({in_item.py[CRD_W-1], in_item.py}) - $signed({cfg.sy[CRD_W-1], cfg.sy});
        bax1_next = $signed({cfg.ex[CRD_W-1], cfg.ex}) - $signed({cfg.sx[CRD_W-1], cfg.sx});
        bay1_next = $signed({cfg.ey[CRD_W-1], cfg.ey}) - $signed({cfg.sy[CRD_W-1], cfg.sy});
        dot3_next = $signed({{2{pbx2_reg[PRD_W-1]}}, pbx2_reg})
                  + $signed({{2{pby2_reg[PRD_W-1]}}, pby2_reg});
        len3_next = {2'b00, bbx2_reg} + {2'b00, bby2_reg};
    end

    // h is 0 for a degenerate segment or a point behind the start,
    // exactly 1.0 past the end, otherwise divided out below
    always_comb
    begin
        logic [DOT_W:0] trial;
        logic           ge;
        zero0 = (len3_reg == '0) || dot3_reg[DOT_W-1] || (dot3_reg == '0);
        full0 = !zero0 && ($unsigned(dot3_reg) >= len3_reg);
        drem_next[0] = (zero0 || full0) ? '0 : $unsigned(dot3_reg);
        dq_next[0] = '0;
        trial = '0;
        ge = 1'b0;
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            trial = {drem_reg[k-1], 1'b0};
            ge = trial >= {1'b0, dlen_reg[k-1]};
            drem_next[k] = ge ? DOT_W'(trial - {1'b0, dlen_reg[k-1]})
                              : trial[DOT_W-1:0];
            dq_next[k] = {dq_reg[k-1][FRAC_BITS-2:0], ge};
        end
    end

    always_comb
    begin
        out_next.item = dit_reg[FRAC_BITS];
        out_next.pax  = dpax_reg[FRAC_BITS];
        out_next.pay  = dpay_reg[FRAC_BITS];
        priority if (dzero_reg[FRAC_BITS])
            out_next.h = '0;
        else if (dfull_reg[FRAC_BITS])
            out_next.h = H_W'(1) << FRAC_BITS;
        else
            out_next.h = {1'b0, dq_reg[FRAC_BITS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            dv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            dv_reg <= {dv_reg[FRAC_BITS-1:0], v3_reg};
            ov_reg <= dv_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg  <= in_item;
            pax1_reg <= pax1_next;
            pay1_reg <= pay1_next;
            bax1_reg <= bax1_next;
            bay1_reg <= bay1_next;

            it2_reg  <= it1_reg;
            pax2_reg <= pax1_reg;
            pay2_reg <= pay1_reg;
            pbx2_reg <= pax1_reg * bax1_reg;
            pby2_reg <= pay1_reg * bay1_reg;
            bbx2_reg <= bax1_reg * bax1_reg;
            bby2_reg <= bay1_reg * bay1_reg;

            it3_reg  <= it2_reg;
            pax3_reg <= pax2_reg;
            pay3_reg <= pay2_reg;
            dot3_reg <= dot3_next;
            len3_reg <= len3_next;

            dit_reg[0]   <= it3_reg;
            dpax_reg[0]  <= pax3_reg;
            dpay_reg[0]  <= pay3_reg;
            dlen_reg[0]  <= len3_reg;
            dzero_reg[0] <= zero0;
            dfull_reg[0] <= full0;
            for (int k = 0; k <= FRAC_BITS; k++)
            begin
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
            end
            for (int k = 1; k <= FRAC_BITS; k++)
            begin
                dit_reg[k]   <= dit_reg[k-1];
                dpax_reg[k]  <= dpax_reg[k-1];
                dpay_reg[k]  <= dpay_reg[k-1];
                dlen_reg[k]  <= dlen_reg[k-1];
                dzero_reg[k] <= dzero_reg[k-1];
                dfull_reg[k] <= dfull_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/segorb_offs.sv =====
// Offset stages: nearest-point offset Q, |Q|^2 against radius^2, and the
// normalising shift of |Qx|, |Qy|. Uses segorb_pkg.
`timescale 1ns / 1ps

module segorb_offs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  segorb_pkg::proj_t in_data,
    input  segorb_pkg::cfg_t  cfg,
    output logic              out_valid,
    output segorb_pkg::norm_t out_data
);
    import segorb_pkg::*;

    logic [7:0] v_reg;

    logic signed [DIF_W-1:0] bax, bay;
    item_t it1_reg, it2_reg, it3_reg, it4_reg;
    logic signed [DIF_W-1:0] pax1_reg, pay1_reg;
    logic signed [HB_W-1:0]  hbx1_reg, hby1_reg, hbx1_next, hby1_next;
    logic signed [HB_W-1:0]  hsx, hsy;
    logic signed [Q_W-1:0]   qx2_reg, qy2_reg, qx2_next, qy2_next;
    logic [MAG_W-1:0]        ax3_reg, ay3_reg, ax3_next, ay3_next;
    logic                    nx3_reg, ny3_reg, nx4_reg, ny4_reg;
    logic [MAG_W-1:0]        ax4_reg, ay4_reg;
    logic [SQ_W-1:0]         sqx4_reg, sqy4_reg;
    logic [RR_W-1:0]         rr4_reg;
    logic [SQ_W:0]           s0_next;
    tag_t                    tag5_reg, tag5_next, tag6_reg, tag7_reg;
    logic [MAG_W-1:0]        ax5_reg, ay5_reg, m5_next, m5_reg;
    logic [MAG_W-1:0]        ax6_reg, ay6_reg, ax7_reg, ay7_reg;
    logic [NGRP-1:0]         any6_reg, any6_next;
    logic [LEAD_W-1:0]       lead6_reg[NGRP];
    logic [LEAD_W-1:0]       lead6_next[NGRP];
    logic [SH_W-1:0]         sh7_reg, sh7_next;
    norm_t                   out_reg, out_next;

    always_comb
    begin
        bax = $signed({cfg.ex[CRD_W-1], cfg.ex}) - $signed({cfg.sx[CRD_W-1], cfg.sx});
        bay = $signed({cfg.ey[CRD_W-1], cfg.ey}) - $signed({cfg.sy[CRD_W-1], cfg.sy});
        hbx1_next = $signed({1'b0, in_data.h}) * bax;
        hby1_next = $signed({1'b0, in_data.h}) * bay;

        // floor of h*(B-A) onto the position grid
        hsx = hbx1_reg >>> FRAC_BITS;
        hsy = hby1_reg >>> FRAC_BITS;
        qx2_next = $signed({{(Q_W-DIF_W){pax1_reg[DIF_W-1]}}, pax1_reg}) - $signed(hsx[Q_W-1:0]);
        qy2_next = $signed({{(Q_W-DIF_W){pay1_reg[DIF_W-1]}}, pay1_reg}) - $signed(hsy[Q_W-1:0]);

        ax3_next = qx2_reg[Q_W-1] ? $unsigned(-qx2_reg) : $unsigned(qx2_reg);
        ay3_next = qy2_reg[Q_W-1] ? $unsigned(-qy2_reg) : $unsigned(qy2_reg);

        s0_next = {1'b0, sqx4_reg} + {1'b0, sqy4_reg};
        tag5_next.item  = it4_reg;
        tag5_next.zero  = (s0_next == '0);
        tag5_next.far   = s0_next >= {{(SQ_W+1-RR_W){1'b0}}, rr4_reg};
        tag5_next.neg_x = nx4_reg;
        tag5_next.neg_y = ny4_reg;
        m5_next = (ax4_reg > ay4_reg) ? ax4_reg : ay4_reg;
    end

    // leading one in each group of bits, then pick the top group
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            any6_next[g]  = 1'b0;
            lead6_next[g] = '0;
            for (int b = 0; b < GRP; b++)
            begin
                if (m5_reg[g*GRP + b])
                begin
                    any6_next[g]  = 1'b1;
                    lead6_next[g] = LEAD_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        logic [SH_W-1:0] p;
        p = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (any6_reg[g])
                p = SH_W'(g*GRP) + SH_W'(lead6_reg[g]);
        end
        sh7_next = (p >= SH_W'(NORM_BIT)) ? '0 : SH_W'(NORM_BIT) - p;
    end

    always_comb
    begin
        out_next.tag = tag7_reg;
        out_next.ax  = ax7_reg << sh7_reg;
        out_next.ay  = ay7_reg << sh7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[6:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg  <= in_data.item;
            pax1_reg <= in_data.pax;
            pay1_reg <= in_data.pay;
            hbx1_reg <= hbx1_next;
            hby1_reg <= hby1_next;

            it2_reg <= it1_reg;
            qx2_reg <= qx2_next;
            qy2_reg <= qy2_next;

            it3_reg <= it2_reg;
            ax3_reg <= ax3_next;
            ay3_reg <= ay3_next;
            nx3_reg <= qx2_reg[Q_W-1];
            ny3_reg <= qy2_reg[Q_W-1];

            it4_reg  <= it3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
            sqx4_reg <= ax3_reg * ax3_reg;
            sqy4_reg <= ay3_reg * ay3_reg;
            rr4_reg  <= cfg.radius * cfg.radius;

            tag5_reg <= tag5_next;
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            m5_reg   <= m5_next;

            tag6_reg <= tag5_reg;
            ax6_reg  <= ax5_reg;
            ay6_reg  <= ay5_reg;
            any6_reg <= any6_next;
            for (int g = 0; g < NGRP; g++)
                lead6_reg[g] <= lead6_next[g];

            tag7_reg <= tag6_reg;
            ax7_reg  <= ax6_reg;
            ay7_reg  <= ay6_reg;
            sh7_reg  <= sh7_next;

            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[7];
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/segorb_sqrt.sv =====
// Square-root stages: squares of the normalised magnitudes, then a
// digit-by-digit integer root, one root bit per stage. Uses segorb_pkg.
`timescale 1ns / 1ps

module segorb_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  segorb_pkg::norm_t in_data,
    output logic              out_valid,
    output segorb_pkg::root_t out_data
);
    import segorb_pkg::*;

    logic            v1_reg;
    logic [ROOT_W:0] sv_reg;

    norm_t          n1_reg;
    logic [SQ_W-1:0] sqa1_reg, sqb1_reg;

    norm_t             sn_reg   [ROOT_W+1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W+1];
    logic [RAD_W-1:0]  rad_next [ROOT_W+1];
    logic [ROOT_W:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W:0]   rem_next [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [ROOT_W-1:0] root_next[ROOT_W+1];

    always_comb
    begin
        logic [ROOT_W+2:0] cur;
        logic [ROOT_W+2:0] trial;
        logic              ge;
        rad_next[0]  = {2'b00, sqa1_reg} + {2'b00, sqb1_reg};
        rem_next[0]  = '0;
        root_next[0] = '0;
        cur   = '0;
        trial = '0;
        ge    = 1'b0;
        for (int k = 1; k <= ROOT_W; k++)
        begin
            cur   = {rem_reg[k-1], rad_reg[k-1][RAD_W-1 -: 2]};
            trial = {1'b0, root_reg[k-1], 2'b01};
            ge    = cur >= trial;
            rem_next[k]  = ge ? (ROOT_W+1)'(cur - trial) : cur[ROOT_W:0];
            root_next[k] = {root_reg[k-1][ROOT_W-2:0], ge};
            rad_next[k]  = rad_reg[k-1] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            sv_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            sv_reg <= {sv_reg[ROOT_W-1:0], v1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= in_data;
            sqa1_reg <= in_data.ax * in_data.ax;
            sqb1_reg <= in_data.ay * in_data.ay;
            sn_reg[0] <= n1_reg;
            for (int k = 1; k <= ROOT_W; k++)
                sn_reg[k] <= sn_reg[k-1];
            for (int k = 0; k <= ROOT_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid     = sv_reg[ROOT_W];
    assign out_data.tag  = sn_reg[ROOT_W].tag;
    assign out_data.ax   = sn_reg[ROOT_W].ax;
    assign out_data.ay   = sn_reg[ROOT_W].ay;
    assign out_data.root = root_reg[ROOT_W];

endmodule

// ===== hw/rtl/segorb_div.sv =====
// Unit-vector dividers (two lanes, one quotient bit per stage), the 75 degree
// rotation and the final position update with output register. Uses segorb_pkg.
`timescale 1ns / 1ps

module segorb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  segorb_pkg::root_t   in_data,
    output logic                out_valid,
    output segorb_pkg::result_t out_data
);
    import segorb_pkg::*;

    logic [H_W:0] dv_reg;
    logic         rv1_reg, rv2_reg, ov_reg;

    logic [NUM_W-1:0] nx, ny;

    tag_t              dt_reg   [H_W+1];
    logic [ROOT_W-1:0] dd_reg   [H_W+1];
    logic [ROOT_W-1:0] rx_reg   [H_W+1];
    logic [ROOT_W-1:0] rx_next  [H_W+1];
    logic [ROOT_W-1:0] ry_reg   [H_W+1];
    logic [ROOT_W-1:0] ry_next  [H_W+1];
    logic [H_W-1:0]    lx_reg   [H_W+1];
    logic [H_W-1:0]    lx_next  [H_W+1];
    logic [H_W-1:0]    ly_reg   [H_W+1];
    logic [H_W-1:0]    ly_next  [H_W+1];
    logic [H_W-1:0]    qx_reg   [H_W+1];
    logic [H_W-1:0]    qx_next  [H_W+1];
    logic [H_W-1:0]    qy_reg   [H_W+1];
    logic [H_W-1:0]    qy_next  [H_W+1];

    tag_t                    t1_reg, t2_reg;
    logic signed [U_W-1:0]   ux, uy;
    logic signed [P_W-1:0]   cx1_reg, sx1_reg, cy1_reg, sy1_reg;
    logic signed [ACC_W-1:0] accx, accy, accx_sh, accy_sh;
    logic signed [RX_W-1:0]  stx2_reg, sty2_reg, stx2_next, sty2_next;
    result_t                 out_reg, out_next;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // numerator |q| * 2^F + d/2; the top part is already below d
    always_comb
    begin
        logic [ROOT_W:0] trx, try_;
        logic            gex, gey;
        nx = {in_data.ax, {FRAC_BITS{1'b0}}} + NUM_W'(in_data.root >> 1);
        ny = {in_data.ay, {FRAC_BITS{1'b0}}} + NUM_W'(in_data.root >> 1);
        rx_next[0] = ROOT_W'(nx[NUM_W-1:H_W]);
        ry_next[0] = ROOT_W'(ny[NUM_W-1:H_W]);
        lx_next[0] = nx[H_W-1:0];
        ly_next[0] = ny[H_W-1:0];
        qx_next[0] = '0;
        qy_next[0] = '0;
        trx  = '0;
        try_ = '0;
        gex  = 1'b0;
        gey  = 1'b0;
        for (int k = 1; k <= H_W; k++)
        begin
            trx  = {rx_reg[k-1], lx_reg[k-1][H_W-1]};
            try_ = {ry_reg[k-1], ly_reg[k-1][H_W-1]};
            gex  = trx >= {1'b0, dd_reg[k-1]};
            gey  = try_ >= {1'b0, dd_reg[k-1]};
            rx_next[k] = gex ? ROOT_W'(trx - {1'b0, dd_reg[k-1]}) : trx[ROOT_W-1:0];
            ry_next[k] = gey ? ROOT_W'(try_ - {1'b0, dd_reg[k-1]}) : try_[ROOT_W-1:0];
            lx_next[k] = lx_reg[k-1] << 1;
            ly_next[k] = ly_reg[k-1] << 1;
            qx_next[k] = {qx_reg[k-1][H_W-2:0], gex};
            qy_next[k] = {qy_reg[k-1][H_W-2:0], gey};
        end
    end

    always_comb
    begin
        ux = dt_reg[H_W].neg_x ? -$signed({1'b0, qx_reg[H_W]}) : $signed({1'b0, qx_reg[H_W]});
        uy = dt_reg[H_W].neg_y ? -$signed({1'b0, qy_reg[H_W]}) : $signed({1'b0, qy_reg[H_W]});

        accx = $signed({cx1_reg[P_W-1], cx1_reg}) - $signed({sy1_reg[P_W-1], sy1_reg}) + HALF;
        accy = $signed({sx1_reg[P_W-1], sx1_reg}) + $signed({cy1_reg[P_W-1], cy1_reg}) + HALF;
        accx_sh = accx >>> FRAC_BITS;
        accy_sh = accy >>> FRAC_BITS;
        // at or beyond the radius the step turns the other way
        stx2_next = t1_reg.far ? -$signed(accx_sh[RX_W-1:0]) : $signed(accx_sh[RX_W-1:0]);
        sty2_next = t1_reg.far ? -$signed(accy_sh[RX_W-1:0]) : $signed(accy_sh[RX_W-1:0]);

        out_next.last = t2_reg.item.last;
        if (t2_reg.zero)
        begin
            out_next.new_x = t2_reg.item.px;
            out_next.new_y = t2_reg.item.py;
        end
        else
        begin
            out_next.new_x = t2_reg.item.px
                           + $signed({{(CRD_W-RX_W){stx2_reg[RX_W-1]}}, stx2_reg});
            out_next.new_y = t2_reg.item.py
                           + $signed({{(CRD_W-RX_W){sty2_reg[RX_W-1]}}, sty2_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg  <= '0;
            rv1_reg <= 1'b0;
            rv2_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            dv_reg  <= {dv_reg[H_W-1:0], in_valid};
            rv1_reg <= dv_reg[H_W];
            rv2_reg <= rv1_reg;
            ov_reg  <= rv2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt_reg[0] <= in_data.tag;
            dd_reg[0] <= in_data.root;
            for (int k = 1; k <= H_W; k++)
            begin
                dt_reg[k] <= dt_reg[k-1];
                dd_reg[k] <= dd_reg[k-1];
            end
            for (int k = 0; k <= H_W; k++)
            begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                lx_reg[k] <= lx_next[k];
                ly_reg[k] <= ly_next[k];
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
            end

            t1_reg  <= dt_reg[H_W];
            cx1_reg <= ux * ROT_C;
            sx1_reg <= ux * ROT_S;
            cy1_reg <= uy * ROT_C;
            sy1_reg <= uy * ROT_S;

            t2_reg   <= t1_reg;
            stx2_reg <= stx2_next;
            sty2_reg <= sty2_next;

            out_reg <= out_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/segment_orbit_step.sv =====
// Top level of the segment orbit step: configuration registers, APB port,
// pipeline hold control and the four pipeline sections. Uses segorb_pkg.
`timescale 1ns / 1ps

// One particle position is accepted per clock while no result is held at the
// output. The pipeline depth is set by the bit-per-stage chains: the
// projection divider, the 36-stage integer square root and the unit-vector
// dividers. A held result freezes the whole pipeline in place, so stall on
// the output goes straight through to stall on the input; otherwise items
// flow back to back. The segment and radius registers must only be written
// while the pipeline is empty.
module segment_orbit_step (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [segorb_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [segorb_pkg::CRD_W-1:0]  pos_x,
    input  logic signed [segorb_pkg::CRD_W-1:0]  pos_y,
    input  logic                                 is_last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [segorb_pkg::CRD_W-1:0]  new_x,
    output logic signed [segorb_pkg::CRD_W-1:0]  new_y,
    output logic                                 last_out
);
    import segorb_pkg::*;

    cfg_t cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic en;

    item_t   in_item;
    logic    proj_valid, offs_valid, root_valid, res_valid;
    proj_t   proj_data;
    norm_t   offs_data;
    root_t   root_data;
    result_t res_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_SEG_START_X: cfg_reg.sx     <= pwdata;
                REG_SEG_START_Y: cfg_reg.sy     <= pwdata;
                REG_SEG_END_X:   cfg_reg.ex     <= pwdata;
                REG_SEG_END_Y:   cfg_reg.ey     <= pwdata;
                REG_ORBIT_RAD:   cfg_reg.radius <= pwdata[RADIUS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SEG_START_X: prdata = cfg_reg.sx;
            REG_SEG_START_Y: prdata = cfg_reg.sy;
            REG_SEG_END_X:   prdata = cfg_reg.ex;
            REG_SEG_END_Y:   prdata = cfg_reg.ey;
            REG_ORBIT_RAD:   prdata = {1'b0, cfg_reg.radius};
            default:         prdata = '0;
        endcase
    end

    // the pipeline only holds while a finished beat waits at the output
    assign en       = !(res_valid && out_stall);
    assign in_stall = !en;

    assign in_item.px   = pos_x;
    assign in_item.py   = pos_y;
    assign in_item.last = is_last;

    segorb_proj u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .out_valid (proj_valid),
        .out_data  (proj_data)
    );

    segorb_offs u_offs (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (proj_valid),
        .in_data   (proj_data),
        .cfg       (cfg_reg),
        .out_valid (offs_valid),
        .out_data  (offs_data)
    );

    segorb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (offs_valid),
        .in_data   (offs_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    segorb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_data   (root_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    assign out_valid = res_valid;
    assign new_x     = res_data.new_x;
    assign new_y     = res_data.new_y;
    assign last_out  = res_data.last;

endmodule
